>>> hw/rtl/assert_macros.svh
// Assertion helpers for clocked checks under the block reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define MPBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication
`define MPBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MPBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mpbm_pkg.sv
package mpbm_pkg;

    localparam int MPBM_NODES    = 4096;
    localparam int MPBM_ALPHABET = 256;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_PATTERN = 2'd1;
    localparam logic [1:0] OP_BUILD   = 2'd2;
    localparam logic [1:0] OP_TEXT    = 2'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_TAG_SWEEP,
        CMD_ROW_SWEEP,
        CMD_CLEAR,
        CMD_P_RD,
        CMD_P_CHK,
        CMD_P_FIN,
        CMD_B_START,
        CMD_B_RR,
        CMD_B_RC,
        CMD_B_POP,
        CMD_B_U,
        CMD_B_W,
        CMD_B_R1,
        CMD_B_R2,
        CMD_B_R3,
        CMD_T_RD,
        CMD_T_GO,
        CMD_T_WALK,
        CMD_T_CHK,
        CMD_T_OUT
    } mpbm_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       fin;
        logic       built;
        logic       dropped;
        logic       hit;
        logic       can_alloc;
        logic       row_last;
        logic       tag_last;
        logic       q_empty;
        logic       walk_done;
        logic       q_wrap;
        logic       out_busy;
    } mpbm_stat_t;

endpackage

>>> hw/rtl/mpbm_ctrl.sv
module mpbm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mpbm_pkg::mpbm_stat_t st,
    output mpbm_pkg::mpbm_cmd_t  cmd
);
    import mpbm_pkg::*;

    typedef enum logic [4:0] {
        S_INIT_TAG,
        S_ROWCLR,
        S_IDLE,
        S_DISP,
        S_CLEAR,
        S_PRD,
        S_PCHK,
        S_PROW,
        S_PFIN,
        S_BSTART,
        S_BRR,
        S_BRC,
        S_BPOP,
        S_BU,
        S_BW,
        S_BR1,
        S_BR2,
        S_BR3,
        S_TRD,
        S_TGO,
        S_TWALK,
        S_TCHK,
        S_TFIN,
        S_WRAP_TAG
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_INIT_TAG: begin
                cmd = CMD_TAG_SWEEP;
                if (st.tag_last) state_next = S_ROWCLR;
            end
            S_ROWCLR: begin
                cmd = CMD_ROW_SWEEP;
                if (st.row_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (st.op)
                    OP_CLEAR:   state_next = S_CLEAR;
                    OP_PATTERN: begin
                        if (st.built)        state_next = S_IDLE;
                        else if (st.dropped) state_next = S_PFIN;
                        else                 state_next = S_PRD;
                    end
                    OP_BUILD:   state_next = S_BSTART;
                    default:    state_next = S_TRD;
                endcase
            end
            S_CLEAR: begin
                cmd        = CMD_CLEAR;
                state_next = S_ROWCLR;
            end
            S_PRD: begin
                cmd        = CMD_P_RD;
                state_next = S_PCHK;
            end
            S_PCHK: begin
                cmd = CMD_P_CHK;
                if (!st.hit && st.can_alloc) state_next = S_PROW;
                else                         state_next = S_PFIN;
            end
            S_PROW: begin
                cmd = CMD_ROW_SWEEP;
                if (st.row_last) state_next = S_PFIN;
            end
            S_PFIN: begin
                cmd        = CMD_P_FIN;
                state_next = S_IDLE;
            end
            S_BSTART: begin
                cmd        = CMD_B_START;
                state_next = st.built ? S_IDLE : S_BRR;
            end
            S_BRR: begin
                cmd        = CMD_B_RR;
                state_next = S_BRC;
            end
            S_BRC: begin
                cmd        = CMD_B_RC;
                state_next = st.row_last ? S_BPOP : S_BRR;
            end
            S_BPOP: begin
                cmd        = CMD_B_POP;
                state_next = st.q_empty ? S_IDLE : S_BU;
            end
            S_BU: begin
                cmd        = CMD_B_U;
                state_next = S_BW;
            end
            S_BW: begin
                cmd        = CMD_B_W;
                state_next = S_BR1;
            end
            S_BR1: begin
                cmd        = CMD_B_R1;
                state_next = S_BR2;
            end
            S_BR2: begin
                cmd        = CMD_B_R2;
                state_next = S_BR3;
            end
            S_BR3: begin
                cmd        = CMD_B_R3;
                state_next = st.row_last ? S_BPOP : S_BR1;
            end
            S_TRD: begin
                cmd        = CMD_T_RD;
                state_next = S_TGO;
            end
            S_TGO: begin
                cmd        = CMD_T_GO;
                state_next = S_TWALK;
            end
            S_TWALK: begin
                if (st.walk_done) begin
                    state_next = S_TFIN;
                end else begin
                    cmd        = CMD_T_WALK;
                    state_next = S_TCHK;
                end
            end
            S_TCHK: begin
                cmd        = CMD_T_CHK;
                state_next = S_TWALK;
            end
            S_TFIN: begin
                if (!st.fin) begin
                    state_next = S_IDLE;
                end else if (!st.out_busy) begin
                    cmd        = CMD_T_OUT;
                    state_next = st.q_wrap ? S_WRAP_TAG : S_IDLE;
                end
            end
            S_WRAP_TAG: begin
                cmd = CMD_TAG_SWEEP;
                if (st.tag_last) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT_TAG;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/mpbm_dp.sv
`include "assert_macros.svh"

module mpbm_dp #(
    parameter int NODES    = mpbm_pkg::MPBM_NODES,
    parameter int ALPHABET = mpbm_pkg::MPBM_ALPHABET
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mpbm_pkg::mpbm_cmd_t  cmd,
    output mpbm_pkg::mpbm_stat_t st,
    input  logic [1:0]           s_operation,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [12:0]          m_match_count,
    output logic                 m_overflow
);
    import mpbm_pkg::*;

    localparam int NW  = $clog2(NODES);
    localparam int SW  = $clog2(ALPHABET);
    localparam int CW  = (NW > SW) ? NW : SW;
    localparam int GAW = NW + SW;
    localparam int GD  = NODES << SW;

    logic [NW-1:0] goto_mem [GD];
    logic [NW-1:0] fail_mem [NODES];
    logic          term_mem [NODES];
    logic [15:0]   tag_mem  [NODES];
    logic [NW-1:0] q_mem    [NODES];

    logic [NW-1:0] g_rdata_reg, f_rdata_reg, q_rdata_reg;
    logic          t_rdata_reg;
    logic [15:0]   tg_rdata_reg;

    logic           g_re, g_we, f_re, f_we, w_re, t_we, tg_we, q_re, q_we;
    logic [GAW-1:0] g_raddr, g_waddr;
    logic [NW-1:0]  g_wdata, f_raddr, f_waddr, f_wdata, t_waddr, tg_waddr;
    logic [NW-1:0]  q_waddr, q_wdata;
    logic           t_wdata;
    logic [15:0]    tg_wdata;

    logic [SW-1:0] sym_lut [256];

    logic [1:0]    op_reg, op_next;
    logic [SW-1:0] sym_reg, sym_next;
    logic          fin_reg, fin_next;
    logic [NW-1:0] cursor_reg, cursor_next;
    logic [NW-1:0] node_cnt_reg, node_cnt_next;
    logic [15:0]   qcnt_reg, qcnt_next;
    logic [12:0]   run_reg, run_next;
    logic          ovf_reg, ovf_next;
    logic          built_reg, built_next;
    logic          dropped_reg, dropped_next;
    logic [NW:0]   head_reg, head_next;
    logic [NW:0]   tail_reg, tail_next;
    logic [NW-1:0] u_reg, u_next;
    logic [NW-1:0] w_reg, w_next;
    logic [NW-1:0] v_reg, v_next;
    logic [NW-1:0] node_reg, node_next;
    logic [NW:0]   steps_reg, steps_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic [12:0]   m_count_reg, m_count_next;
    logic          m_ovf_reg, m_ovf_next;

    logic [NW-1:0] new_node;
    logic [SW-1:0] cnt_sym;
    logic          row_last, tag_last, can_alloc;

    for (genvar i = 0; i < 256; i++) begin : g_sym
        assign sym_lut[i] = SW'(i % ALPHABET);
    end

    assign new_node  = node_cnt_reg + 1'b1;
    assign cnt_sym   = cnt_reg[SW-1:0];
    assign row_last  = (cnt_reg == CW'(ALPHABET - 1));
    assign tag_last  = (cnt_reg == CW'(NODES - 1));
    assign can_alloc = (node_cnt_reg != NW'(NODES - 1));

    always_comb begin
        st.op        = op_reg;
        st.fin       = fin_reg;
        st.built     = built_reg;
        st.dropped   = dropped_reg;
        st.hit       = (g_rdata_reg != '0);
        st.can_alloc = can_alloc;
        st.row_last  = row_last;
        st.tag_last  = tag_last;
        st.q_empty   = (head_reg == tail_reg);
        st.walk_done = (node_reg == '0) || (steps_reg == (NW+1)'(NODES));
        st.q_wrap    = (qcnt_reg == 16'hFFFF);
        st.out_busy  = m_valid_reg && !m_ready;
    end

    always_comb begin
        op_next       = op_reg;
        sym_next      = sym_reg;
        fin_next      = fin_reg;
        cursor_next   = cursor_reg;
        node_cnt_next = node_cnt_reg;
        qcnt_next     = qcnt_reg;
        run_next      = run_reg;
        ovf_next      = ovf_reg;
        built_next    = built_reg;
        dropped_next  = dropped_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        u_next        = u_reg;
        w_next        = w_reg;
        v_next        = v_reg;
        node_next     = node_reg;
        steps_next    = steps_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_count_next  = m_count_reg;
        m_ovf_next    = m_ovf_reg;

        g_re     = 1'b0;
        g_raddr  = {cursor_reg, sym_reg};
        g_we     = 1'b0;
        g_waddr  = {cursor_reg, cnt_sym};
        g_wdata  = '0;
        f_re     = 1'b0;
        f_raddr  = node_reg;
        f_we     = 1'b0;
        f_waddr  = new_node;
        f_wdata  = '0;
        w_re     = 1'b0;
        t_we     = 1'b0;
        t_waddr  = new_node;
        t_wdata  = 1'b0;
        tg_we    = 1'b0;
        tg_waddr = new_node;
        tg_wdata = '0;
        q_re     = 1'b0;
        q_we     = 1'b0;
        q_waddr  = tail_reg[NW-1:0];
        q_wdata  = g_rdata_reg;

        case (cmd)
            CMD_LOAD: begin
                op_next  = s_operation;
                sym_next = sym_lut[s_data_byte];
                fin_next = s_last;
            end
            CMD_TAG_SWEEP: begin
                tg_we    = 1'b1;
                tg_waddr = cnt_reg[NW-1:0];
                cnt_next = tag_last ? '0 : cnt_reg + 1'b1;
            end
            CMD_ROW_SWEEP: begin
                g_we     = 1'b1;
                cnt_next = row_last ? '0 : cnt_reg + 1'b1;
            end
            CMD_CLEAR: begin
                node_cnt_next = '0;
                cursor_next   = '0;
                run_next      = '0;
                ovf_next      = 1'b0;
                built_next    = 1'b0;
                dropped_next  = 1'b0;
            end
            CMD_P_RD: begin
                g_re = 1'b1;
            end
            CMD_P_CHK: begin
                if (g_rdata_reg != '0) begin
                    cursor_next = g_rdata_reg;
                end else if (can_alloc) begin
                    node_cnt_next = new_node;
                    cursor_next   = new_node;
                    g_we          = 1'b1;
                    g_waddr       = {cursor_reg, sym_reg};
                    g_wdata       = new_node;
                    f_we          = 1'b1;
                    t_we          = 1'b1;
                    tg_we         = 1'b1;
                end else begin
                    ovf_next     = 1'b1;
                    dropped_next = 1'b1;
                end
            end
            CMD_P_FIN: begin
                if (fin_reg) begin
                    if (!dropped_reg) begin
                        t_we    = 1'b1;
                        t_waddr = cursor_reg;
                        t_wdata = 1'b1;
                    end
                    cursor_next  = '0;
                    dropped_next = 1'b0;
                end
            end
            CMD_B_START: begin
                cursor_next  = '0;
                dropped_next = 1'b0;
                if (!built_reg) begin
                    built_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                    cnt_next   = '0;
                end
            end
            CMD_B_RR: begin
                g_re    = 1'b1;
                g_raddr = {NW'(0), cnt_sym};
            end
            CMD_B_RC: begin
                if ((g_rdata_reg != '0) && (tail_reg < (NW+1)'(NODES))) begin
                    f_we      = 1'b1;
                    f_waddr   = g_rdata_reg;
                    q_we      = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                cnt_next = row_last ? '0 : cnt_reg + 1'b1;
            end
            CMD_B_POP: begin
                if (head_reg != tail_reg) begin
                    q_re      = 1'b1;
                    head_next = head_reg + 1'b1;
                end
            end
            CMD_B_U: begin
                u_next  = q_rdata_reg;
                f_re    = 1'b1;
                f_raddr = q_rdata_reg;
            end
            CMD_B_W: begin
                w_next = f_rdata_reg;
            end
            CMD_B_R1: begin
                g_re    = 1'b1;
                g_raddr = {u_reg, cnt_sym};
            end
            CMD_B_R2: begin
                v_next  = g_rdata_reg;
                g_re    = 1'b1;
                g_raddr = {w_reg, cnt_sym};
            end
            CMD_B_R3: begin
                if (v_reg == '0) begin
                    g_we    = 1'b1;
                    g_waddr = {u_reg, cnt_sym};
                    g_wdata = g_rdata_reg;
                end else if (tail_reg < (NW+1)'(NODES)) begin
                    f_we      = 1'b1;
                    f_waddr   = v_reg;
                    f_wdata   = g_rdata_reg;
                    q_we      = 1'b1;
                    q_wdata   = v_reg;
                    tail_next = tail_reg + 1'b1;
                end
                cnt_next = row_last ? '0 : cnt_reg + 1'b1;
            end
            CMD_T_RD: begin
                g_re = 1'b1;
            end
            CMD_T_GO: begin
                cursor_next = g_rdata_reg;
                node_next   = g_rdata_reg;
                steps_next  = '0;
            end
            CMD_T_WALK: begin
                f_re = 1'b1;
                w_re = 1'b1;
            end
            CMD_T_CHK: begin
                if (t_rdata_reg && (tg_rdata_reg != qcnt_reg)) begin
                    tg_we    = 1'b1;
                    tg_waddr = node_reg;
                    tg_wdata = qcnt_reg;
                    if (run_reg != 13'h1FFF) run_next = run_reg + 1'b1;
                end
                node_next  = f_rdata_reg;
                steps_next = steps_reg + 1'b1;
            end
            CMD_T_OUT: begin
                m_valid_next = 1'b1;
                m_count_next = run_reg;
                m_ovf_next   = ovf_reg;
                cursor_next  = '0;
                run_next     = '0;
                qcnt_next    = (qcnt_reg == 16'hFFFF) ? 16'd1 : qcnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (g_we) goto_mem[g_waddr] <= g_wdata;
        if (g_re) g_rdata_reg <= goto_mem[g_raddr];
        if (f_we) fail_mem[f_waddr] <= f_wdata;
        if (f_re) f_rdata_reg <= fail_mem[f_raddr];
        if (t_we) term_mem[t_waddr] <= t_wdata;
        if (w_re) t_rdata_reg <= term_mem[node_reg];
        if (tg_we) tag_mem[tg_waddr] <= tg_wdata;
        if (w_re) tg_rdata_reg <= tag_mem[node_reg];
        if (q_we) q_mem[q_waddr] <= q_wdata;
        if (q_re) q_rdata_reg <= q_mem[head_reg[NW-1:0]];
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        sym_reg     <= sym_next;
        fin_reg     <= fin_next;
        u_reg       <= u_next;
        w_reg       <= w_next;
        v_reg       <= v_next;
        node_reg    <= node_next;
        steps_reg   <= steps_next;
        m_count_reg <= m_count_next;
        m_ovf_reg   <= m_ovf_next;
        if (!aresetn) begin
            cursor_reg   <= '0;
            node_cnt_reg <= '0;
            qcnt_reg     <= 16'd1;
            run_reg      <= '0;
            ovf_reg      <= 1'b0;
            built_reg    <= 1'b0;
            dropped_reg  <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            cursor_reg   <= cursor_next;
            node_cnt_reg <= node_cnt_next;
            qcnt_reg     <= qcnt_next;
            run_reg      <= run_next;
            ovf_reg      <= ovf_next;
            built_reg    <= built_next;
            dropped_reg  <= dropped_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_count = m_count_reg;
    assign m_overflow    = m_ovf_reg;

    `MPBM_ASSERT(a_head_le_tail, head_reg <= tail_reg, "queue head passed tail")
    `MPBM_ASSERT_IMP(a_out_text, cmd == CMD_T_OUT, (op_reg == OP_TEXT) && fin_reg,
        "result from a request that is not a final text byte")
    `MPBM_ASSERT_NXT(a_clear_root, cmd == CMD_CLEAR, cursor_reg == '0,
        "cursor not at root after clear")
    `MPBM_ASSERT_NXT(a_out_reset, cmd == CMD_T_OUT, (run_reg == '0) && m_valid_reg,
        "count not restarted after result")

endmodule

>>> hw/rtl/multi_pattern_byte_matcher.sv
// Multi-pattern byte matcher (Aho-Corasick automaton).
// Input channel s_*: one request per byte; s_operation selects clear,
// pattern byte, build or text byte, s_last ends a pattern or a query.
// Result channel m_*: one result for each text byte with s_last set,
// carrying the distinct-pattern count of that query and the overflow flag.
// One request is worked at a time; s_ready is high only when idle.
// A pattern byte that adds a node also sweeps its goto row to zero
// through the single write port; a text byte walks the failure chain
// with one fail/mark/tag read per node; clear sweeps the root row;
// build scans the root row and then each queued trie node's row, its
// reads going through the single goto read port.
// After reset the block sweeps the tag store and the root row before
// s_ready rises; every 65535 queries the tag store is swept again.
// Results sit in an output register; a stalled receiver holds only a
// final text byte whose result would overwrite a waiting one.
module multi_pattern_byte_matcher #(
    parameter int NODES    = mpbm_pkg::MPBM_NODES,
    parameter int ALPHABET = mpbm_pkg::MPBM_ALPHABET
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [12:0] m_match_count,
    output logic        m_overflow
);
    import mpbm_pkg::*;

    mpbm_cmd_t  cmd;
    mpbm_stat_t st;

    mpbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mpbm_dp #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .s_operation   (s_operation),
        .s_data_byte   (s_data_byte),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_count (m_match_count),
        .m_overflow    (m_overflow)
    );

endmodule
